// ===== hw/rtl/handle_first_fit_pool_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the handle-based pool allocator
// Immediate-consequence and next-cycle forms, clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef HANDLE_FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH
`define HANDLE_FIRST_FIT_POOL_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define HFFA_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hffa assertion failed");

// next-cycle implication
`define HFFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hffa assertion failed");

`endif

// ===== hw/rtl/hffa_pkg.sv =====
// ----------------------------------------------------------------------------
// hffa_pkg
// Types and codes shared by the pool allocator and its table memories.
// ----------------------------------------------------------------------------
package hffa_pkg;

  // request opcodes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_FREE    = 3'd1;
  localparam logic [2:0] OP_REALLOC = 3'd2;
  localparam logic [2:0] OP_DEFRAG  = 3'd3;
  localparam logic [2:0] OP_QUERY   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] handle;
    logic [31:0] request_size;
  } hffa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] new_handle;
    logic [31:0] block_address;
    logic [31:0] block_size;
    logic [31:0] old_address;
    logic [31:0] copy_length;
  } hffa_rsp_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [31:0] offset;
    logic [31:0] length;
  } live_entry_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
  } freed_entry_t;

endpackage

// ===== hw/rtl/hffa_live_mem.sv =====
// ----------------------------------------------------------------------------
// hffa_live_mem
// Live block table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hffa_live_mem import hffa_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [AW-1:0] waddr_i,
  input  live_entry_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output live_entry_t rdata_o
);

  live_entry_t mem_q [DEPTH];
  live_entry_t rdata_q;

  // write then registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hffa_freed_mem.sv =====
// ----------------------------------------------------------------------------
// hffa_freed_mem
// Freed block list: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hffa_freed_mem import hffa_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic         clk_i,
  input  logic         we_i,
  input  logic [AW-1:0] waddr_i,
  input  freed_entry_t wdata_i,
  input  logic [AW-1:0] raddr_i,
  output freed_entry_t rdata_o
);

  freed_entry_t mem_q [DEPTH];
  freed_entry_t rdata_q;

  // write then registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/handle_first_fit_pool_allocator.sv =====
// Sequencing: query and free each scan the live table; alloc scans the freed list and then
// the live table, plus the freed-list shift when a freed block is reused; realloc is free
// plus alloc. Defrag: for each freed entry, a pass over the live table and later freed entries.
// Throughput: one request at a time; each entry scan reads one memory word per cycle.
// Reset: control, counters and valid bits clear at once; memories need no clearing pass.
`include "handle_first_fit_pool_allocator_defines.svh"
// ----------------------------------------------------------------------------
// handle_first_fit_pool_allocator
// Handle-based first-fit allocator with a live table and a freed list held in
// memories, sequenced by one state machine.
// ----------------------------------------------------------------------------
module handle_first_fit_pool_allocator import hffa_pkg::*; #(
  parameter int unsigned LIVE_SLOTS  = 64,
  parameter int unsigned FREED_SLOTS = 64,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hffa_req_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hffa_rsp_t   out_data_o
);

  localparam int unsigned LW = $clog2(LIVE_SLOTS);
  localparam int unsigned FW = $clog2(FREED_SLOTS);
  localparam logic [33:0] OFF_LIMIT = 34'((64'd1 << OFFSET_BITS) - 64'd1);
  localparam logic [31:0] OFF_MASK  = OFF_LIMIT[31:0];
  localparam logic [LW:0] LIVE_N    = (LW+1)'(LIVE_SLOTS);
  localparam logic [FW:0] FREED_N   = (FW+1)'(FREED_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FREE_WR, S_FIT, S_LSCAN, S_PLACE, S_SHIFT, S_LWR,
    S_DF_RD, S_DF_K, S_DF_LIVE, S_DF_FREE, S_DONE
  } state_e;

  state_e          state_q;
  logic [31:0]     base_q, size_q, nh_q;
  logic [FW:0]     cnt_q, fscan_q, k_q;
  logic [LW:0]     scan_q;
  logic [LIVE_SLOTS-1:0] valid_q;
  hffa_req_t       req_q;
  hffa_rsp_t       res_q, out_q;
  logic            out_valid_q;
  logic            rd_vld_q;
  logic [LW-1:0]   rd_lidx_q, slot_q, match_idx_q, free_idx_q;
  logic [FW-1:0]   rd_fidx_q, fit_idx_q;
  logic            found_q, fit_q, best_vld_q, match_q, free_vld_q;
  logic [31:0]     old_off_q, old_len_q, fit_off_q, place_off_q;
  logic [31:0]     best_off_q, best_len_q, best_h_q, dlen_q;
  logic [32:0]     end_q;

  // memory ports
  logic            lw_en, fw_en;
  logic [LW-1:0]   lw_addr, lr_addr;
  logic [FW-1:0]   fw_addr, fr_addr;
  live_entry_t     lw_data, lr_data;
  freed_entry_t    fw_data, fr_data;

  hffa_live_mem #(.DEPTH(LIVE_SLOTS), .AW(LW)) u_live (
    .clk_i(clk_i), .we_i(lw_en), .waddr_i(lw_addr), .wdata_i(lw_data),
    .raddr_i(lr_addr), .rdata_o(lr_data)
  );

  hffa_freed_mem #(.DEPTH(FREED_SLOTS), .AW(FW)) u_freed (
    .clk_i(clk_i), .we_i(fw_en), .waddr_i(fw_addr), .wdata_i(fw_data),
    .raddr_i(fr_addr), .rdata_o(fr_data)
  );

  // scan pipeline status
  logic live_issue, freed_issue, rd_valid_bit;
  logic f_hit, l_end, f_end, fit_hit, full;
  assign live_issue   = scan_q < LIVE_N;
  assign freed_issue  = fscan_q < cnt_q;
  assign rd_valid_bit = valid_q[rd_lidx_q];
  assign f_hit   = rd_vld_q && rd_valid_bit && (lr_data.handle == req_q.handle);
  assign l_end   = !live_issue && !rd_vld_q;
  assign f_end   = !freed_issue && !rd_vld_q;
  assign fit_hit = rd_vld_q && (fr_data.length >= req_q.request_size);
  assign full    = cnt_q == FREED_N;

  // placement after the highest live block
  logic [32:0] start_w;
  logic [33:0] end_w;
  logic        nomem;
  assign start_w = best_vld_q ? ({1'b0, best_off_q} + {1'b0, best_len_q}) : 33'd0;
  assign end_w   = {1'b0, start_w} + {2'b0, req_q.request_size};
  assign nomem   = !fit_q && ((end_w > {2'b0, size_q}) || (end_w > OFF_LIMIT));

  // memory access control
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = rd_lidx_q;
    lw_data = lr_data;
    lr_addr = scan_q[LW-1:0];
    fw_en   = 1'b0;
    fw_addr = rd_fidx_q;
    fw_data = fr_data;
    fr_addr = fscan_q[FW-1:0];
    unique case (state_q)
      S_FREE_WR: begin
        fw_en   = 1'b1;
        fw_addr = cnt_q[FW-1:0];
        fw_data = '{offset: old_off_q, length: old_len_q};
      end
      S_SHIFT: begin
        fw_en   = rd_vld_q;
        fw_addr = rd_fidx_q - FW'(1);
      end
      S_LWR: begin
        lw_en   = 1'b1;
        lw_addr = slot_q;
        lw_data = '{handle: nh_q, offset: place_off_q, length: req_q.request_size};
      end
      S_DF_RD: begin
        fr_addr = k_q[FW-1:0];
      end
      S_DF_LIVE: begin
        lw_en = rd_vld_q && rd_valid_bit && ({1'b0, lr_data.offset} >= end_q);
        lw_data.offset = (lr_data.offset - dlen_q) & OFF_MASK;
      end
      S_DF_FREE: begin
        fw_en = rd_vld_q && ({1'b0, fr_data.offset} >= end_q);
        fw_data.offset = (fr_data.offset - dlen_q) & OFF_MASK;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      size_q      <= 32'd65536;
      nh_q        <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      scan_q      <= '0;
      fscan_q     <= '0;
      k_q         <= '0;
    end else begin
      // configuration
      if (cfg_we_i) begin
        if (cfg_idx_i) begin
          size_q <= cfg_wdata_i;
        end else begin
          base_q <= cfg_wdata_i;
        end
      end
      // result beat taken; S_DONE reloads it itself
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q    <= in_data_i;
            res_q    <= '0;
            found_q  <= 1'b0;
            fit_q    <= 1'b0;
            rd_vld_q <= 1'b0;
            scan_q   <= '0;
            fscan_q  <= '0;
            k_q      <= '0;
            priority case (in_data_i.opcode)
              OP_ALLOC:  state_q <= S_FIT;
              OP_FREE, OP_REALLOC, OP_QUERY: state_q <= S_FIND;
              OP_DEFRAG: state_q <= S_DF_RD;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_FIND: begin
          rd_vld_q  <= live_issue && !(f_hit || l_end);
          rd_lidx_q <= scan_q[LW-1:0];
          if (live_issue) begin
            scan_q <= scan_q + 1'b1;
          end
          if (f_hit || l_end) begin
            found_q   <= f_hit;
            slot_q    <= rd_lidx_q;
            old_off_q <= lr_data.offset;
            old_len_q <= lr_data.length;
            fscan_q   <= '0;
            priority case (req_q.opcode)
              OP_QUERY: begin
                state_q <= S_DONE;
                if (f_hit) begin
                  res_q.block_address <= base_q + lr_data.offset;
                  res_q.block_size    <= lr_data.length;
                end else begin
                  res_q.status <= ST_NOT_FOUND;
                end
              end
              OP_FREE: begin
                if (!f_hit) begin
                  res_q.status <= ST_NOT_FOUND;
                  state_q      <= S_DONE;
                end else if (full) begin
                  res_q.status <= ST_TABLE_FULL;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_FREE_WR;
                end
              end
              default: begin
                if (f_hit && full) begin
                  res_q.status <= ST_TABLE_FULL;
                  state_q      <= S_DONE;
                end else if (f_hit) begin
                  state_q <= S_FREE_WR;
                end else begin
                  state_q <= S_FIT;
                end
              end
            endcase
          end
        end
        S_FREE_WR: begin
          cnt_q           <= cnt_q + 1'b1;
          valid_q[slot_q] <= 1'b0;
          fscan_q         <= '0;
          state_q         <= (req_q.opcode == OP_FREE) ? S_DONE : S_FIT;
        end
        S_FIT: begin
          rd_vld_q  <= freed_issue && !(fit_hit || f_end);
          rd_fidx_q <= fscan_q[FW-1:0];
          if (freed_issue) begin
            fscan_q <= fscan_q + 1'b1;
          end
          if (fit_hit || f_end) begin
            fit_q      <= fit_hit;
            fit_idx_q  <= rd_fidx_q;
            fit_off_q  <= fr_data.offset;
            scan_q     <= '0;
            best_vld_q <= 1'b0;
            match_q    <= 1'b0;
            free_vld_q <= 1'b0;
            state_q    <= S_LSCAN;
          end
        end
        S_LSCAN: begin
          rd_vld_q  <= live_issue;
          rd_lidx_q <= scan_q[LW-1:0];
          if (live_issue) begin
            scan_q <= scan_q + 1'b1;
          end
          if (rd_vld_q) begin
            if (rd_valid_bit) begin
              if (!best_vld_q || lr_data.offset > best_off_q ||
                  (lr_data.offset == best_off_q && lr_data.handle < best_h_q)) begin
                best_vld_q <= 1'b1;
                best_off_q <= lr_data.offset;
                best_len_q <= lr_data.length;
                best_h_q   <= lr_data.handle;
              end
              if (!match_q && lr_data.handle == nh_q) begin
                match_q     <= 1'b1;
                match_idx_q <= rd_lidx_q;
              end
            end else if (!free_vld_q) begin
              free_vld_q <= 1'b1;
              free_idx_q <= rd_lidx_q;
            end
          end
          if (l_end) begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          place_off_q <= fit_q ? fit_off_q : (start_w[31:0] & OFF_MASK);
          slot_q      <= match_q ? match_idx_q : free_idx_q;
          fscan_q     <= {1'b0, fit_idx_q} + 1'b1;
          rd_vld_q    <= 1'b0;
          if (nomem) begin
            res_q.status <= ST_NO_MEMORY;
            state_q      <= S_DONE;
          end else if (!match_q && !free_vld_q) begin
            res_q.status <= ST_TABLE_FULL;
            state_q      <= S_DONE;
          end else begin
            state_q <= fit_q ? S_SHIFT : S_LWR;
          end
        end
        S_SHIFT: begin
          rd_vld_q  <= freed_issue;
          rd_fidx_q <= fscan_q[FW-1:0];
          if (freed_issue) begin
            fscan_q <= fscan_q + 1'b1;
          end
          if (f_end) begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_LWR;
          end
        end
        S_LWR: begin
          valid_q[slot_q]     <= 1'b1;
          nh_q                <= nh_q + 32'd1;
          res_q.status        <= ST_OK;
          res_q.new_handle    <= nh_q;
          res_q.block_address <= base_q + place_off_q;
          res_q.block_size    <= req_q.request_size;
          if (req_q.opcode == OP_REALLOC && found_q) begin
            res_q.old_address <= base_q + old_off_q;
            res_q.copy_length <= (old_len_q < req_q.request_size) ? old_len_q
                                                                   : req_q.request_size;
          end
          state_q <= S_DONE;
        end
        S_DF_RD: begin
          if (k_q >= cnt_q) begin
            cnt_q   <= '0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_DF_K;
          end
        end
        S_DF_K: begin
          end_q    <= {1'b0, fr_data.offset} + {1'b0, fr_data.length};
          dlen_q   <= fr_data.length;
          scan_q   <= '0;
          rd_vld_q <= 1'b0;
          state_q  <= S_DF_LIVE;
        end
        S_DF_LIVE: begin
          rd_vld_q  <= live_issue;
          rd_lidx_q <= scan_q[LW-1:0];
          if (live_issue) begin
            scan_q <= scan_q + 1'b1;
          end
          if (l_end) begin
            fscan_q <= k_q + 1'b1;
            state_q <= S_DF_FREE;
          end
        end
        S_DF_FREE: begin
          rd_vld_q  <= freed_issue;
          rd_fidx_q <= fscan_q[FW-1:0];
          if (freed_issue) begin
            fscan_q <= fscan_q + 1'b1;
          end
          if (f_end) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_DF_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `HFFA_ASSERT(a_cnt_bound, 1'b1, cnt_q <= FREED_N)
  `HFFA_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, state_q != S_IDLE)
  `HFFA_ASSERT(a_fail_zero, out_valid_o && out_data_o.status != ST_OK, out_data_o.new_handle == '0 && out_data_o.block_size == '0 && out_data_o.copy_length == '0)
  `HFFA_ASSERT_NXT(a_handle_step, state_q == S_LWR, nh_q == $past(nh_q) + 32'd1)

endmodule
